[sv/cits_pkg.sv]
// Shared types and constants for the conditional init-table sequencer.
// No dependencies; used by cits_ctrl, cits_action and the top level.
package cits_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_WORD  = 2'd1,
    ACT_RF    = 2'd2,
    ACT_DELAY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    BR_IF    = 2'd0,
    BR_ELIF  = 2'd1,
    BR_ELSE  = 2'd2,
    BR_ENDIF = 2'd3
  } branch_e;

  typedef enum logic [1:0] {
    KIND_MAC = 2'd0,
    KIND_AGC = 2'd1,
    KIND_BB  = 2'd2,
    KIND_RF  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_CUT        = 3'd0,
    CFG_PACKAGE    = 3'd1,
    CFG_INTERFACE  = 3'd2,
    CFG_RFE        = 3'd3,
    CFG_KIND       = 3'd4,
    CFG_PATH_SEL   = 3'd5,
    CFG_PATH_COUNT = 3'd6
  } cfg_idx_e;

  // Delay opcodes carried in entry_addr
  localparam logic [31:0] BB_DLY_50MS  = 32'h0000_00fe;
  localparam logic [31:0] BB_DLY_5MS   = 32'h0000_00fd;
  localparam logic [31:0] BB_DLY_1MS   = 32'h0000_00fc;
  localparam logic [31:0] BB_DLY_50US  = 32'h0000_00fb;
  localparam logic [31:0] BB_DLY_5US   = 32'h0000_00fa;
  localparam logic [31:0] BB_DLY_1US   = 32'h0000_00f9;
  localparam logic [31:0] RF_DLY_50MS  = 32'h0000_0ffe;
  localparam logic [31:0] RF_DLY_100US = 32'h0000_00fe;

  localparam logic [15:0] US_50000 = 16'd50000;
  localparam logic [15:0] US_5000  = 16'd5000;
  localparam logic [15:0] US_1000  = 16'd1000;
  localparam logic [15:0] US_100   = 16'd100;
  localparam logic [15:0] US_50    = 16'd50;
  localparam logic [15:0] US_5     = 16'd5;
  localparam logic [15:0] US_1     = 16'd1;

  localparam logic [31:0] RF_DATA_MASK = 32'h000f_ffff;
  localparam logic [31:0] RF_WORD_MASK = 32'h0fff_ffff;
  localparam logic [31:0] COUNT_MAX    = 32'hffff_ffff;

  typedef struct packed {
    logic [3:0] chip_cut;
    logic [3:0] chip_package;
    logic [3:0] chip_interface;
    logic [7:0] chip_rfe;
    kind_e      table_kind;
    logic       rf_path_sel;
    logic [1:0] rf_path_count;
  } chip_cfg_t;

  typedef struct packed {
    logic        start_of_table;
    logic        is_positive;
    logic        is_negative;
    branch_e     branch_code;
    logic [3:0]  cond_cut;
    logic [3:0]  cond_package;
    logic [3:0]  cond_interface;
    logic [7:0]  cond_rfe;
    logic [31:0] entry_addr;
    logic [31:0] entry_data;
  } tile_t;

  // Action formed from a config tile, before the matched flag gates it
  typedef struct packed {
    logic        emit;
    logic        bump;
    action_e     action;
    logic [31:0] target_addr;
    logic [31:0] write_value;
    logic [15:0] delay_us;
  } act_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] target_addr;
    logic [31:0] write_value;
    logic [15:0] delay_us;
    logic [31:0] applied_count;
  } result_t;

endpackage

[sv/cits_ctrl.sv]
// Branch flags, latched condition and applied-write counter.
// Depends on cits_pkg; advances once per tile taken from the input register.
module cits_ctrl
  import cits_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  tile_t       tile_i,
  input  chip_cfg_t   cfg_i,
  input  logic        bump_i,
  output logic        go_o,
  output logic [31:0] count_o
);

  logic        matched_q, matched_d;
  logic        skipped_q, skipped_d;
  logic [3:0]  lat_cut_q, lat_cut_d;
  logic [3:0]  lat_pkg_q, lat_pkg_d;
  logic [3:0]  lat_intf_q, lat_intf_d;
  logic [7:0]  lat_rfe_q, lat_rfe_d;
  logic [31:0] count_q, count_d;

  logic        m0, s0, cond_ok, is_cfg;
  logic [3:0]  cut0, pkg0, intf0;
  logic [7:0]  rfe0;
  logic [31:0] cnt0;

  always_comb begin
    // start of table resets flags (matched set), latched condition and count before the tile is applied
    m0    = tile_i.start_of_table ? 1'b1  : matched_q;
    s0    = tile_i.start_of_table ? 1'b0  : skipped_q;
    cut0  = tile_i.start_of_table ? 4'd0  : lat_cut_q;
    pkg0  = tile_i.start_of_table ? 4'd0  : lat_pkg_q;
    intf0 = tile_i.start_of_table ? 4'd0  : lat_intf_q;
    rfe0  = tile_i.start_of_table ? 8'd0  : lat_rfe_q;
    cnt0  = tile_i.start_of_table ? 32'd0 : count_q;

    // zero in cut, package or interface means any value
    cond_ok = ((cut0 == 4'd0) || (cut0 == cfg_i.chip_cut)) &&
              ((pkg0 == 4'd0) || (pkg0 == cfg_i.chip_package)) &&
              ((intf0 == 4'd0) || (intf0 == cfg_i.chip_interface)) &&
              (rfe0 == cfg_i.chip_rfe);

    is_cfg = !tile_i.is_positive && !tile_i.is_negative;

    matched_d  = m0;
    skipped_d  = s0;
    lat_cut_d  = cut0;
    lat_pkg_d  = pkg0;
    lat_intf_d = intf0;
    lat_rfe_d  = rfe0;
    count_d    = cnt0;

    if (tile_i.is_positive) begin
      case (tile_i.branch_code)
        BR_ENDIF: begin
          matched_d = 1'b1;
          skipped_d = 1'b0;
        end
        BR_ELSE: begin
          matched_d = !s0;
        end
        default: begin
          lat_cut_d  = tile_i.cond_cut;
          lat_pkg_d  = tile_i.cond_package;
          lat_intf_d = tile_i.cond_interface;
          lat_rfe_d  = tile_i.cond_rfe;
        end
      endcase
    end else if (tile_i.is_negative) begin
      if (!s0) begin
        matched_d = cond_ok;
        skipped_d = cond_ok;
      end else begin
        matched_d = 1'b0;
      end
    end else if (m0 && bump_i && (cnt0 != COUNT_MAX)) begin
      count_d = cnt0 + 32'd1;
    end

    go_o    = is_cfg && m0;
    count_o = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q  <= 1'b1;
      skipped_q  <= 1'b0;
      lat_cut_q  <= 4'd0;
      lat_pkg_q  <= 4'd0;
      lat_intf_q <= 4'd0;
      lat_rfe_q  <= 8'd0;
      count_q    <= 32'd0;
    end else if (step_i) begin
      matched_q  <= matched_d;
      skipped_q  <= skipped_d;
      lat_cut_q  <= lat_cut_d;
      lat_pkg_q  <= lat_pkg_d;
      lat_intf_q <= lat_intf_d;
      lat_rfe_q  <= lat_rfe_d;
      count_q    <= count_d;
    end
  end

  // a stepped negative tile while skipped always drops the matched flag
  a_neg_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tile_i.is_negative && !tile_i.is_positive && s0 |=> !matched_q)
    else $error("matched flag survived a negative tile while skipped");

  // the count never wraps from saturation to zero without a new table
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !tile_i.start_of_table && (count_q == COUNT_MAX) |=> count_q == COUNT_MAX)
    else $error("applied count left saturation");

endmodule

[sv/cits_action.sv]
// Forms the action of a config tile from the table kind.
// Depends on cits_pkg; purely combinational, fed from the input register.
module cits_action
  import cits_pkg::*;
#(
  parameter logic [15:0] SipiPortA = 16'd3216,
  parameter logic [15:0] SipiPortB = 16'd3728
) (
  input  tile_t     tile_i,
  input  chip_cfg_t cfg_i,
  output act_t      act_o
);

  logic [31:0] addr, data;

  always_comb begin
    addr = tile_i.entry_addr;
    data = tile_i.entry_data;

    act_o             = '0;
    act_o.emit        = 1'b1;
    act_o.action      = ACT_WORD;
    act_o.target_addr = addr;

    case (cfg_i.table_kind)
      KIND_MAC: begin
        act_o.bump        = 1'b1;
        act_o.action      = ACT_BYTE;
        act_o.write_value = {24'd0, data[7:0]};
      end
      KIND_AGC: begin
        act_o.bump        = 1'b1;
        act_o.write_value = data;
      end
      KIND_BB: begin
        act_o.target_addr = 32'd0;
        act_o.action      = ACT_DELAY;
        case (addr)
          BB_DLY_50MS: act_o.delay_us = US_50000;
          BB_DLY_5MS:  act_o.delay_us = US_5000;
          BB_DLY_1MS:  act_o.delay_us = US_1000;
          BB_DLY_50US: act_o.delay_us = US_50;
          BB_DLY_5US:  act_o.delay_us = US_5;
          BB_DLY_1US:  act_o.delay_us = US_1;
          default: begin
            act_o.bump        = 1'b1;
            act_o.action      = ACT_WORD;
            act_o.target_addr = addr;
            act_o.write_value = data;
          end
        endcase
      end
      default: begin
        if (addr == RF_DLY_50MS) begin
          act_o.action      = ACT_DELAY;
          act_o.target_addr = 32'd0;
          act_o.delay_us    = US_50000;
        end else if (addr == RF_DLY_100US) begin
          act_o.action      = ACT_DELAY;
          act_o.target_addr = 32'd0;
          act_o.delay_us    = US_100;
        end else begin
          // count the write even when the path is absent, but drop the beat
          act_o.bump        = 1'b1;
          act_o.emit        = ({1'b0, cfg_i.rf_path_sel} < cfg_i.rf_path_count);
          act_o.action      = ACT_RF;
          act_o.target_addr = {16'd0, (cfg_i.rf_path_sel ? SipiPortB : SipiPortA)};
          act_o.write_value = ({4'd0, addr[7:0], 20'd0} | (data & RF_DATA_MASK))
                              & RF_WORD_MASK;
        end
      end
    endcase
  end

endmodule

[sv/conditional_init_table_sequencer.sv]
// Conditional init-table sequencer: input register, flag/action logic, result register.
// Path: an accepted tile waits in the input register, then its result beat is captured in the result register.
// Throughput: one tile per cycle, limited only by the result register draining.
// Reset: rst_ni clears flags (matched set), latched condition and count; config to defaults.
// Depends on cits_pkg, cits_ctrl and cits_action.
module conditional_init_table_sequencer
  import cits_pkg::*;
#(
  parameter logic [15:0] SIPI_PORT_A = 16'd3216,
  parameter logic [15:0] SIPI_PORT_B = 16'd3728
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: cond_cut, cond_package, cond_interface, cond_rfe, entry_addr, entry_data, pad
  input  logic [87:0]  s_axis_tdata,
  // tuser: start_of_table, is_positive, is_negative, branch_code[1:0]
  input  logic [4:0]   s_axis_tuser,
  // master side
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: target_addr, write_value, delay_us, applied_count
  output logic [111:0] m_axis_tdata,
  // tuser: action
  output logic [1:0]   m_axis_tuser,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  chip_cfg_t   cfg_q;
  tile_t       tile_q, tile_in;
  logic        in_valid_q;
  result_t     res_q;
  logic        out_valid_q;
  logic        advance, go;
  logic [31:0] count;
  act_t        act;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chip_cut       <= 4'd15;
      cfg_q.chip_package   <= 4'd15;
      cfg_q.chip_interface <= 4'd0;
      cfg_q.chip_rfe       <= 8'd0;
      cfg_q.table_kind     <= KIND_MAC;
      cfg_q.rf_path_sel    <= 1'b0;
      cfg_q.rf_path_count  <= 2'd1;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_CUT:        cfg_q.chip_cut       <= cfg_data_i[3:0];
        CFG_PACKAGE:    cfg_q.chip_package   <= cfg_data_i[3:0];
        CFG_INTERFACE:  cfg_q.chip_interface <= cfg_data_i[3:0];
        CFG_RFE:        cfg_q.chip_rfe       <= cfg_data_i[7:0];
        CFG_KIND:       cfg_q.table_kind     <= kind_e'(cfg_data_i[1:0]);
        CFG_PATH_SEL:   cfg_q.rf_path_sel    <= cfg_data_i[0];
        CFG_PATH_COUNT: cfg_q.rf_path_count  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tile_in.start_of_table = s_axis_tuser[0];
    tile_in.is_positive    = s_axis_tuser[1];
    tile_in.is_negative    = s_axis_tuser[2];
    tile_in.branch_code    = branch_e'(s_axis_tuser[4:3]);
    tile_in.cond_cut       = s_axis_tdata[3:0];
    tile_in.cond_package   = s_axis_tdata[7:4];
    tile_in.cond_interface = s_axis_tdata[11:8];
    tile_in.cond_rfe       = s_axis_tdata[19:12];
    tile_in.entry_addr     = s_axis_tdata[51:20];
    tile_in.entry_data     = s_axis_tdata[83:52];
  end

  // the registered tile moves on whenever the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tile_q <= tile_in;
    end
  end

  cits_action #(
    .SipiPortA(SIPI_PORT_A),
    .SipiPortB(SIPI_PORT_B)
  ) u_action (
    .tile_i(tile_q),
    .cfg_i (cfg_q),
    .act_o (act)
  );

  cits_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tile_i (tile_q),
    .cfg_i  (cfg_q),
    .bump_i (act.bump),
    .go_o   (go),
    .count_o(count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && go && act.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && go && act.emit) begin
      res_q.action        <= act.action;
      res_q.target_addr   <= act.target_addr;
      res_q.write_value   <= act.write_value;
      res_q.delay_us      <= act.delay_us;
      res_q.applied_count <= count;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.action;
  assign m_axis_tdata  = {res_q.applied_count, res_q.delay_us,
                          res_q.write_value, res_q.target_addr};

  a_delay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.action == ACT_DELAY) |->
      (res_q.target_addr == 32'd0) && (res_q.write_value == 32'd0) && (res_q.delay_us != 16'd0))
    else $error("delay beat carries a write");

  a_write_no_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.action != ACT_DELAY) |-> res_q.delay_us == 16'd0)
    else $error("write beat carries a delay");

  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.action == ACT_BYTE) |-> res_q.write_value[31:8] == 24'd0)
    else $error("byte write wider than a byte");

  a_stall_holds_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stalled tile dropped from input register");

endmodule
